[rtl/core/iuj_pkg.sv]
`timescale 1ns / 1ps

package iuj_pkg;

  localparam int JOURNAL_DEPTH = 64;
  localparam int JRN_ADDR_W    = $clog2(JOURNAL_DEPTH);
  localparam int JRN_CNT_W     = $clog2(JOURNAL_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT = 1'd1;

  // commands
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_UNDO   = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // RV32I major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;

  // store widths
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_HALF = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [4:0]  dest_reg;
    logic [31:0] current_pc;
    logic [31:0] old_rd_value;
    logic [31:0] store_addr;
    logic [31:0] old_mem_bytes;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        restore_valid;
    logic [31:0] restore_pc;
    logic [4:0]  restore_reg_index;
    logic [31:0] restore_reg_value;
    logic [2:0]  restore_mem_count;
    logic [31:0] restore_mem_addr;
    logic [31:0] restore_mem_data;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [2:0]  mem_count;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic writes_rd(input logic [6:0] op);
    return (op == OP_REG) || (op == OP_IMM) || (op == OP_LOAD) || (op == OP_JAL) ||
           (op == OP_JALR) || (op == OP_AUIPC) || (op == OP_LUI);
  endfunction

endpackage

[rtl/core/iuj_ram.sv]
`timescale 1ns / 1ps

module iuj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/instruction_undo_journal.sv]
`timescale 1ns / 1ps

// Undo journal for an RV32I emulator core.
// Input channel (in_valid / in_stall / in_req): a record request pushes the
// instruction's PC plus either the old rd value or up to four old store bytes;
// an undo request pops the newest entry and returns its restore values.
// Result channel (out_valid / out_stall / out_rsp): exactly one result per
// request, in order. status reports full on a refused record and empty on an
// undo with nothing journaled; restore fields are zero unless restore_valid.
// Configuration (cfg_we / cfg_index / cfg_wdata): data_base and mem_limit, to be
// written only while the block is idle; the user must ensure it, the block does not.
// An accepted request passes through the first stage, then the result register;
// one request is taken every cycle unless the result side stalls. The journal RAM
// read port is registered; the entry counter is the only state carried between requests.
// Reset clears the entry count and both pipeline stages and sets data_base
// to 0 and mem_limit to all ones; journal contents are not cleared.
// While the receiver stalls, the result register holds and the first stage
// fills; after that the input stalls until the result is taken.

module instruction_undo_journal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  iuj_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output iuj_pkg::out_rsp_t             out_rsp,
  input  logic                          cfg_we,
  input  logic [iuj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iuj_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import iuj_pkg::*;

  logic [31:0] data_base_r;
  logic [31:0] mem_limit_r;

  logic [JRN_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [1:0]           s1_status_r, s1_status_nxt;
  logic                 s1_pop_r, s1_pop_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_rsp_t             out_rsp_r, out_rsp_nxt;

  logic                 acc;
  logic                 s1_adv;
  logic                 full, empty;
  logic                 push, pop;
  logic [JRN_CNT_W-1:0] top_idx;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic [2:0]           st_n;
  logic [32:0]          st_end;

  assign s1_adv   = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  assign full    = (cnt_r == JRN_CNT_W'(JOURNAL_DEPTH));
  assign empty   = (cnt_r == '0);
  assign push    = acc && (in_req.cmd == CMD_RECORD) && !full;
  assign pop     = acc && (in_req.cmd == CMD_UNDO) && !empty;
  assign top_idx = cnt_r - JRN_CNT_W'(1);

  // entry built from the record request
  always_comb begin
    st_n = 3'd0;
    unique case (in_req.funct3)
      F3_BYTE: st_n = 3'd1;
      F3_HALF: st_n = 3'd2;
      F3_WORD: st_n = 3'd4;
      default: st_n = 3'd0;
    endcase
    st_end = {1'b0, in_req.store_addr} + {30'd0, st_n};

    wr_entry    = '0;
    wr_entry.pc = in_req.current_pc;
    if (writes_rd(in_req.opcode)) begin
      wr_entry.reg_index = in_req.dest_reg;
      wr_entry.reg_value = in_req.old_rd_value;
    end else if (in_req.opcode == OP_STORE) begin
      if (st_n != 3'd0 && in_req.store_addr >= data_base_r &&
          st_end <= {1'b0, mem_limit_r}) begin
        wr_entry.mem_count = st_n;
        wr_entry.mem_addr  = in_req.store_addr;
        case (st_n)
          3'd1:    wr_entry.mem_data = {24'd0, in_req.old_mem_bytes[7:0]};
          3'd2:    wr_entry.mem_data = {16'd0, in_req.old_mem_bytes[15:0]};
          default: wr_entry.mem_data = in_req.old_mem_bytes;
        endcase
      end
    end
  end

  iuj_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(JOURNAL_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (push),
    .waddr(cnt_r[JRN_ADDR_W-1:0]),
    .wdata(wr_entry),
    .re   (pop),
    .raddr(top_idx[JRN_ADDR_W-1:0]),
    .rdata(rd_entry)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = cnt_r + JRN_CNT_W'(1);
    end else if (pop) begin
      cnt_nxt = top_idx;
    end

    s1_vld_nxt    = s1_vld_r;
    s1_status_nxt = s1_status_r;
    s1_pop_nxt    = s1_pop_r;
    if (acc) begin
      s1_vld_nxt = 1'b1;
      s1_pop_nxt = pop;
      if (in_req.cmd == CMD_RECORD) begin
        s1_status_nxt = full ? STATUS_FULL : STATUS_OK;
      end else begin
        s1_status_nxt = empty ? STATUS_EMPTY : STATUS_OK;
      end
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    out_rsp_nxt = out_rsp_r;
    if (s1_adv) begin
      out_vld_nxt = s1_vld_r;
      out_rsp_nxt = '0;
      out_rsp_nxt.status = s1_status_r;
      if (s1_pop_r) begin
        out_rsp_nxt.restore_valid     = 1'b1;
        out_rsp_nxt.restore_pc        = rd_entry.pc;
        out_rsp_nxt.restore_reg_index = rd_entry.reg_index;
        out_rsp_nxt.restore_reg_value = rd_entry.reg_value;
        out_rsp_nxt.restore_mem_count = rd_entry.mem_count;
        out_rsp_nxt.restore_mem_addr  = rd_entry.mem_addr;
        out_rsp_nxt.restore_mem_data  = rd_entry.mem_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= '0;
      mem_limit_r <= '1;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      s1_pop_r    <= 1'b0;
      s1_status_r <= STATUS_OK;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DATA_BASE: data_base_r <= cfg_wdata;
          CFG_MEM_LIMIT: mem_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      cnt_r       <= cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s1_pop_r    <= s1_pop_nxt;
      s1_status_r <= s1_status_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import iuj_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 300;
  localparam int PHASES         = 5;
  localparam int TAIL_CYCLES    = 8;

  // values outside the defined sets, used to reach the default paths
  localparam logic [2:0] F3_BAD   = 3'd3;
  localparam logic [6:0] OP_UNDEF = 7'h7F;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DATA_BASE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  instruction_undo_journal u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // journal shadow: one undo record per pushed request
  typedef struct packed {
    logic [31:0] pc;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic [2:0]  byte_cnt;
    logic [31:0] byte_addr;
    logic [31:0] byte_data;
  } undo_rec_t;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;

  undo_rec_t   jrn [JOURNAL_DEPTH];
  int          jrn_count = 0;
  logic [31:0] win_base  = 32'h0000_0000;
  logic [31:0] win_limit = 32'hFFFF_FFFF;

  out_rsp_t pending_rsp [$];
  out_rsp_t rsp_want;
  dir_row_t dir_rows [$];

  int send_idle_pct = 28;
  int rcv_idle_pct  = 55;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  int mismatches = 0;
  int n_checked  = 0;
  int n_records  = 0;
  int n_undos    = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int max_fill   = 0;
  int n_windows  = 0;

  function automatic out_rsp_t journal_apply(input in_req_t r);
    out_rsp_t    rsp;
    undo_rec_t   rec;
    logic [2:0]  nbytes;
    logic [31:0] mask;
    logic [32:0] span_end;
    rsp = '0;
    rsp.status = STATUS_OK;
    if (r.cmd == CMD_RECORD) begin
      n_records++;
      if (jrn_count >= JOURNAL_DEPTH) begin
        rsp.status = STATUS_FULL;
        n_full++;
      end else begin
        rec = '0;
        rec.pc = r.current_pc;
        case (r.opcode)
          OP_REG, OP_IMM, OP_LOAD, OP_JAL, OP_JALR, OP_AUIPC, OP_LUI: begin
            rec.reg_idx = r.dest_reg;
            rec.reg_val = r.old_rd_value;
          end
          OP_STORE: begin
            case (r.funct3)
              F3_BYTE: begin
                nbytes = 3'd1;
                mask   = 32'h0000_00FF;
              end
              F3_HALF: begin
                nbytes = 3'd2;
                mask   = 32'h0000_FFFF;
              end
              F3_WORD: begin
                nbytes = 3'd4;
                mask   = 32'hFFFF_FFFF;
              end
              default: begin
                nbytes = 3'd0;
                mask   = 32'h0;
              end
            endcase
            // end of the stored span, kept one bit wider so it cannot wrap
            span_end = {1'b0, r.store_addr} + 33'(nbytes);
            if (nbytes != 3'd0 && r.store_addr >= win_base &&
                span_end <= {1'b0, win_limit}) begin
              rec.byte_cnt  = nbytes;
              rec.byte_addr = r.store_addr;
              rec.byte_data = r.old_mem_bytes & mask;
            end
          end
          default: ;
        endcase
        jrn[jrn_count] = rec;
        jrn_count++;
        if (jrn_count > max_fill) max_fill = jrn_count;
      end
    end else begin
      n_undos++;
      if (jrn_count == 0) begin
        rsp.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        jrn_count--;
        rec = jrn[jrn_count];
        rsp.restore_valid     = 1'b1;
        rsp.restore_pc        = rec.pc;
        rsp.restore_reg_index = rec.reg_idx;
        rsp.restore_reg_value = rec.reg_val;
        rsp.restore_mem_count = rec.byte_cnt;
        rsp.restore_mem_addr  = rec.byte_addr;
        rsp.restore_mem_data  = rec.byte_data;
      end
    end
    return rsp;
  endfunction

  function automatic in_req_t mk_req(input logic cmd, input logic [6:0] op,
                                     input logic [2:0] f3, input logic [4:0] rd,
                                     input logic [31:0] pc, input logic [31:0] oldv,
                                     input logic [31:0] addr, input logic [31:0] bytes);
    in_req_t r;
    r.cmd           = cmd;
    r.opcode        = op;
    r.funct3        = f3;
    r.dest_reg      = rd;
    r.current_pc    = pc;
    r.old_rd_value  = oldv;
    r.store_addr    = addr;
    r.old_mem_bytes = bytes;
    return r;
  endfunction

  function automatic out_rsp_t mk_rsp(input logic [1:0] st, input logic vld,
                                      input logic [31:0] pc, input logic [4:0] idx,
                                      input logic [31:0] val, input logic [2:0] cnt,
                                      input logic [31:0] addr, input logic [31:0] data);
    out_rsp_t r;
    r.status            = st;
    r.restore_valid     = vld;
    r.restore_pc        = pc;
    r.restore_reg_index = idx;
    r.restore_reg_value = val;
    r.restore_mem_count = cnt;
    r.restore_mem_addr  = addr;
    r.restore_mem_data  = data;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_req_t rand_req(input int undo_pct);
    in_req_t r;
    int      pick;
    r.cmd = ($urandom_range(99) < undo_pct) ? CMD_UNDO : CMD_RECORD;
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.opcode = OP_STORE;
    end else if (pick < 88) begin
      case ($urandom_range(8))
        0:       r.opcode = OP_REG;
        1:       r.opcode = OP_IMM;
        2:       r.opcode = OP_SYSTEM;
        3:       r.opcode = OP_BRANCH;
        4:       r.opcode = OP_LOAD;
        5:       r.opcode = OP_JAL;
        6:       r.opcode = OP_JALR;
        7:       r.opcode = OP_AUIPC;
        default: r.opcode = OP_LUI;
      endcase
    end else begin
      r.opcode = 7'($urandom);
    end
    r.funct3        = ($urandom_range(99) < 85) ? 3'($urandom_range(2)) : 3'($urandom);
    r.dest_reg      = 5'($urandom);
    r.current_pc    = rand_word();
    r.old_rd_value  = rand_word();
    r.old_mem_bytes = rand_word();
    // half of the addresses sit on the window edges, a quarter just above the base
    case ($urandom_range(3))
      0:       r.store_addr = win_base + 32'($urandom_range(8)) - 32'd4;
      1:       r.store_addr = win_limit - 32'($urandom_range(8));
      2:       r.store_addr = win_base + 32'($urandom_range(255));
      default: r.store_addr = rand_word();
    endcase
    return r;
  endfunction

  task automatic offer(input in_req_t r, input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = journal_apply(r);
    pending_rsp.push_back(typed ? typed_rsp : want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic set_window(input logic [31:0] base, input logic [31:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    win_base = base;
    cfg_index <= CFG_MEM_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    win_limit = lim;
    cfg_we <= 1'b0;
    n_windows++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on %s in result %0d: expected %h, got %h",
                 what, n_checked, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall, long hold-off on request, in-order compare
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    if (out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        if (mismatches < 10)
          $display("result with nothing pending: %h", out_rsp);
        mismatches++;
      end else begin
        rsp_want = pending_rsp.pop_front();
        check_field("status", 32'(rsp_want.status), 32'(out_rsp.status));
        check_field("restore_valid", 32'(rsp_want.restore_valid),
                    32'(out_rsp.restore_valid));
        check_field("restore_pc", rsp_want.restore_pc, out_rsp.restore_pc);
        check_field("restore_reg_index", 32'(rsp_want.restore_reg_index),
                    32'(out_rsp.restore_reg_index));
        check_field("restore_reg_value", rsp_want.restore_reg_value,
                    out_rsp.restore_reg_value);
        check_field("restore_mem_count", 32'(rsp_want.restore_mem_count),
                    32'(out_rsp.restore_mem_count));
        check_field("restore_mem_addr", rsp_want.restore_mem_addr,
                    out_rsp.restore_mem_addr);
        check_field("restore_mem_data", rsp_want.restore_mem_data,
                    out_rsp.restore_mem_data);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no request or result moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int mode;

    // directed requests under the reset window (base 0, limit all ones)
    dir_rows.push_back('{mk_req(CMD_UNDO, 7'h0, F3_BYTE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0),
                         1'b1, mk_rsp(STATUS_EMPTY, 1'b0, 32'h0, 5'd0, 32'h0, 3'd0,
                                      32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_LUI, F3_WORD, 5'd31, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                         1'b1, mk_rsp(STATUS_OK, 1'b0, 32'h0, 5'd0, 32'h0, 3'd0,
                                      32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_UNDO, 7'h0, F3_BYTE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0),
                         1'b1, mk_rsp(STATUS_OK, 1'b1, 32'hFFFF_FFFF, 5'd31,
                                      32'hFFFF_FFFF, 3'd0, 32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_UNDO, 7'h7F, 3'd7, 5'd31, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                         1'b1, mk_rsp(STATUS_EMPTY, 1'b0, 32'h0, 5'd0, 32'h0, 3'd0,
                                      32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_STORE, F3_WORD, 5'd31, 32'h0,
                                32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF),
                         1'b1, mk_rsp(STATUS_OK, 1'b0, 32'h0, 5'd0, 32'h0, 3'd0,
                                      32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_UNDO, 7'h0, F3_BYTE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0),
                         1'b1, mk_rsp(STATUS_OK, 1'b1, 32'h0, 5'd0, 32'h0, 3'd4,
                                      32'h0, 32'hFFFF_FFFF)});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_STORE, F3_BYTE, 5'd7, 32'h4,
                                32'h0, 32'hFFFF_FFFE, 32'h1234_5678),
                         1'b1, mk_rsp(STATUS_OK, 1'b0, 32'h0, 5'd0, 32'h0, 3'd0,
                                      32'h0, 32'h0)});
    dir_rows.push_back('{mk_req(CMD_UNDO, 7'h0, F3_BYTE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0),
                         1'b1, mk_rsp(STATUS_OK, 1'b1, 32'h4, 5'd0, 32'h0, 3'd1,
                                      32'hFFFF_FFFE, 32'h0000_0078)});
    // half store ending exactly on the limit, then spans one past it
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_STORE, F3_HALF, 5'd0, 32'h8,
                                32'h0, 32'hFFFF_FFFD, 32'hA5A5_C3C3), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_STORE, F3_HALF, 5'd0, 32'hC,
                                32'h0, 32'hFFFF_FFFE, 32'hA5A5_C3C3), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_STORE, F3_WORD, 5'd0, 32'h10,
                                32'h0, 32'hFFFF_FFFC, 32'h0BAD_F00D), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_STORE, F3_BAD, 5'd3, 32'h14,
                                32'h1, 32'h0000_0100, 32'h5555_AAAA), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_SYSTEM, F3_BYTE, 5'd5, 32'h18,
                                32'h0000_1234, 32'h0000_0200, 32'h1111_2222), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_UNDEF, F3_HALF, 5'd9, 32'h1C,
                                32'h0000_4321, 32'h0000_0300, 32'h3333_4444), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_REG, F3_BYTE, 5'd0, 32'h20,
                                32'hDEAD_BEEF, 32'h0, 32'h0), 1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_RECORD, OP_JALR, F3_BYTE, 5'd1, 32'h24,
                                32'h0000_0005, 32'h0, 32'h0), 1'b0, '0});
    repeat (8)
      dir_rows.push_back('{mk_req(CMD_UNDO, 7'h0, F3_BYTE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0),
                           1'b0, '0});
    dir_rows.push_back('{mk_req(CMD_UNDO, 7'h0, F3_BYTE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0),
                         1'b1, mk_rsp(STATUS_EMPTY, 1'b0, 32'h0, 5'd0, 32'h0, 3'd0,
                                      32'h0, 32'h0)});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       set_window(32'h0000_1000, 32'h0000_2000);
        1:       set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2:       set_window(32'h0000_0000, 32'h0000_0000);
        3:       set_window(32'h8000_0000, 32'hFFFF_FFFF);
        default: set_window(32'h0000_0000, 32'hFFFF_FFFF);
      endcase
      mode = ph * 3 / PHASES;
      send_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 55 : 0;
      rcv_idle_pct <= (mode == 0) ? 55 : (mode == 1) ? 28 : 0;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver holds off while requests keep coming, so the input backs up
        if (i == 100 && (ph == 0 || ph == PHASES - 1)) hold_reqs <= hold_reqs + 1;
        offer(rand_req(45), 1'b0, '0);
      end
      // overfill the journal, then undo past empty
      if (ph == 0 || ph == 3) begin
        repeat (JOURNAL_DEPTH + 6) offer(rand_req(0), 1'b0, '0);
        repeat (JOURNAL_DEPTH + 8) offer(rand_req(100), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d requests (%0d record, %0d undo), %0d window settings, fill up to %0d",
             n_records + n_undos, n_records, n_undos, n_windows, max_fill);
    $display("run: %0d results compared, %0d refused as full, %0d undos on empty",
             n_checked, n_full, n_empty);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/iuj_pkg.sv
rtl/core/iuj_ram.sv
rtl/core/instruction_undo_journal.sv
verif/tb_top.sv
